@@ src/wto_pkg.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared types, codes and constants of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

   // Table geometry. The table depth is a power of two.
   localparam int TABLE_DEPTH = 2048;
   localparam int TABLE_COUNT = 6;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SEL_W       = 3;
   localparam int MEM_DEPTH   = TABLE_COUNT * TABLE_DEPTH;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);

   // Item field widths.
   localparam int OPCODE_W  = 3;
   localparam int LEVEL_W   = 17;
   localparam int STEP_W    = 24;
   localparam int TADDR_W   = 11;
   localparam int SAMPLE_W  = 16;
   localparam int PHASE_W   = 32;
   localparam int FRAC_W    = 8;
   localparam int AMP_W     = 7;

   // Shared multiplier.
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;

   // Scaling constants. The division by 127 * 65536 is a shift by 16 followed
   // by a multiplication with a reciprocal of 127 that is exact below 2^22.
   localparam int LEVEL_FRAC_W = 16;
   localparam int RECIP_SHIFT  = 29;
   localparam logic [MUL_W-1:0] RECIP_127 = 25'd4227331;
   localparam logic [22:0] CLAMP_LIMIT = 23'd4161536;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'd32767;
   localparam logic [LEVEL_W-1:0] SILENT_LEVEL = 17'd65;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SELECT = 1'd1;
   localparam logic [AMP_W-1:0] AMP_RESET = 7'd127;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK        = 3'd0,
      OP_NOTE_ON     = 3'd1,
      OP_NOTE_OFF    = 3'd2,
      OP_RESET       = 3'd3,
      OP_TABLE_WRITE = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_MUL_INTERP,
      ST_INTERP,
      ST_MUL_AMP,
      ST_MUL_ENV,
      ST_MUL_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]        opcode;
      logic [LEVEL_W-1:0]         env_level;
      logic                       env_off;
      logic [STEP_W-1:0]          phase_step;
      logic [SEL_W-1:0]           table_select;
      logic [TADDR_W-1:0]         table_addr;
      logic signed [SAMPLE_W-1:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
   } rsp_item_type;

   typedef struct packed {
      logic                    en;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_op_type;

endpackage

@@ src/wto_if.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface wto_req_if;
   import wto_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface wto_rsp_if;
   import wto_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

@@ src/wto_wave_mem.sv @@
// ----------------------------------------------------------------------------
// Wave table memory
// Holds all tables in one array with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module wto_wave_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [wto_pkg::ADDR_W-1:0]          wr_addr,
   input  logic signed [wto_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [wto_pkg::ADDR_W-1:0]          rd_addr,
   output logic signed [wto_pkg::SAMPLE_W-1:0] rd_data
);
   import wto_pkg::*;

   logic signed [SAMPLE_W-1:0] wave_mem_ff [MEM_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wave_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= wave_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/wto_mul_unit.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, used for interpolation,
// amplitude, envelope and reciprocal scaling in turn.
// ----------------------------------------------------------------------------
module wto_mul_unit (
   input  logic                              clock,
   input  wto_pkg::mul_op_type               mul_op,
   output logic signed [wto_pkg::PROD_W-1:0] prod
);
   import wto_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_op.en) begin
         prod_in = mul_op.a * mul_op.b;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ src/wavetable_oscillator_interp.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// A sample tick gives its item from the output state; items are taken only
// in the idle state. The shared multiplier is used four times, the last three
// in a row. A silent tick goes straight to the output state; a result that
// still waits on the result channel holds that state. Synchronous reset clears
// phase, step, gate and wave select, sets amplitude to 127; tables keep data.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp (
   input  logic                                   clock,
   input  logic                                   reset,
   wto_req_if.sink                                req_ch,
   wto_rsp_if.source                              rsp_ch,
   input  logic                                   csr_we,
   input  logic [wto_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [wto_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import wto_pkg::*;

   state_type                  state_ff, state_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       gate_ff, gate_in;
   logic [AMP_W-1:0]           amp_ff, amp_in;
   logic [SEL_W-1:0]           wsel_ff, wsel_in;
   logic [LEVEL_W-1:0]         env_ff, env_in;
   logic                       silent_ff, silent_in;
   logic signed [SAMPLE_W-1:0] s1_ff, s1_in;
   logic                       sign_ff, sign_in;
   logic [SAMPLE_W-1:0]        mag_ff, mag_in;
   logic                       clamp_ff, clamp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       silent_now;
   logic [IDX_W-1:0]           idx;
   logic [IDX_W-1:0]           nxt;
   logic [FRAC_W-1:0]          frac;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W:0]   interp;
   logic [22:0]                scaled;
   logic [SAMPLE_W-1:0]        quot;
   logic [SAMPLE_W-1:0]        mag_out;
   mul_op_type                 mul_op;
   logic signed [PROD_W-1:0]   prod;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign silent_now = req_ch.item.env_off &&
                       (!gate_ff || (req_ch.item.env_level <= SILENT_LEVEL));

   assign idx  = phase_ff[FRAC_W +: IDX_W];
   assign nxt  = idx + 1'b1;
   assign frac = phase_ff[FRAC_W-1:0];

   assign wr_en = req_accept && (req_ch.item.opcode == OP_TABLE_WRITE) &&
                  (32'(req_ch.item.table_select) < TABLE_COUNT) &&
                  (32'(req_ch.item.table_addr) < TABLE_DEPTH);
   assign wr_addr = ADDR_W'({req_ch.item.table_select, req_ch.item.table_addr[IDX_W-1:0]});
   assign rd_addr = (state_ff == ST_RD1) ? ADDR_W'({wsel_ff, nxt}) : ADDR_W'({wsel_ff, idx});

   assign diff    = {rd_data[SAMPLE_W-1], rd_data} - {s1_ff[SAMPLE_W-1], s1_ff};
   assign interp  = {s1_ff[SAMPLE_W-1], s1_ff} + prod[FRAC_W +: SAMPLE_W+1];
   assign scaled  = prod[LEVEL_FRAC_W +: 23];
   assign quot    = prod[RECIP_SHIFT +: SAMPLE_W];
   assign mag_out = clamp_ff ? SAMPLE_MAX : quot;

   wto_wave_mem u_wave_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.item.table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wto_mul_unit u_mul_unit (
      .clock  (clock),
      .mul_op (mul_op),
      .prod   (prod)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      gate_in      = gate_ff;
      amp_in       = amp_ff;
      wsel_in      = wsel_ff;
      env_in       = env_ff;
      silent_in    = silent_ff;
      s1_in        = s1_ff;
      sign_in      = sign_ff;
      mag_in       = mag_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      sample_in    = sample_ff;
      mul_op       = '0;
      req_ch.ready = (state_ff == ST_IDLE);

      if (csr_we) begin
         case (csr_index)
            CSR_AMPLITUDE: begin
               amp_in = csr_wdata[AMP_W-1:0];
            end
            CSR_WAVE_SELECT: begin
               if (32'(csr_wdata[SEL_W-1:0]) < TABLE_COUNT) begin
                  wsel_in = csr_wdata[SEL_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.item.opcode)
                  OP_TICK: begin
                     env_in    = req_ch.item.env_level;
                     silent_in = silent_now;
                     state_in  = silent_now ? ST_OUT : ST_RD1;
                  end
                  OP_NOTE_ON: begin
                     gate_in = 1'b1;
                     step_in = req_ch.item.phase_step;
                  end
                  OP_NOTE_OFF: begin
                     gate_in = 1'b0;
                  end
                  OP_RESET: begin
                     phase_in = '0;
                     gate_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD1: begin
            s1_in    = rd_data;
            state_in = ST_MUL_INTERP;
         end
         ST_MUL_INTERP: begin
            mul_op.en = 1'b1;
            mul_op.a  = MUL_W'(diff);
            mul_op.b  = $signed(MUL_W'(frac));
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            sign_in  = interp[SAMPLE_W];
            mag_in   = interp[SAMPLE_W] ? SAMPLE_W'(-interp) : SAMPLE_W'(interp);
            state_in = ST_MUL_AMP;
         end
         ST_MUL_AMP: begin
            mul_op.en = 1'b1;
            mul_op.a  = $signed(MUL_W'(mag_ff));
            mul_op.b  = $signed(MUL_W'(amp_ff));
            state_in  = ST_MUL_ENV;
         end
         ST_MUL_ENV: begin
            mul_op.en = 1'b1;
            mul_op.a  = $signed(MUL_W'(prod[21:0]));
            mul_op.b  = $signed(MUL_W'(env_ff));
            state_in  = ST_MUL_DIV;
         end
         ST_MUL_DIV: begin
            clamp_in  = (scaled >= CLAMP_LIMIT);
            mul_op.en = 1'b1;
            mul_op.a  = $signed(MUL_W'(scaled[21:0]));
            mul_op.b  = $signed(RECIP_127);
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (silent_ff) begin
                  sample_in = '0;
               end else begin
                  sample_in = sign_ff ? -$signed(mag_out) : $signed(mag_out);
                  phase_in  = phase_ff + PHASE_W'(step_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         gate_ff      <= 1'b0;
         amp_ff       <= AMP_RESET;
         wsel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         gate_ff      <= gate_in;
         amp_ff       <= amp_in;
         wsel_ff      <= wsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      env_ff    <= env_in;
      silent_ff <= silent_in;
      s1_ff     <= s1_in;
      sign_ff   <= sign_in;
      mag_ff    <= mag_in;
      clamp_ff  <= clamp_in;
      sample_ff <= sample_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.item.sample_out = sample_ff;

`ifndef SYNTH
   a_silent_phase_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && silent_ff && rsp_free) |=> (phase_ff == $past(phase_ff)))
      else $error("Phase moved on a silent tick.");

   a_tick_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.item.opcode == OP_TICK && !silent_now) |=> (state_ff == ST_RD1))
      else $error("Audible tick did not start the table read.");

   a_interp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_AMP) |-> (mag_ff <= 16'd32768))
      else $error("Interpolated magnitude out of range.");

   a_no_negative_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (sample_ff != 16'sh8000))
      else $error("Result item was not clamped.");
`endif

endmodule

@@ test/wavetable_oscillator_interp_test.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator testbench
// Writes each table entry before its first read, drives directed cases and
// random note sequences through the request channel and register settings
// through the configuration port. A predictor in the testbench computes each
// expected sample, and every result item is compared with it.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp_test;
   import wto_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 17'd65536;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;
   localparam longint FULL_SCALE = 127 * 65536;
   localparam int RANDOM_ITEMS = 800;
   localparam int SETTLE_CYCLES = 10;
   localparam int IDLE_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wto_req_if req_ch ();
   wto_rsp_if rsp_ch ();

   wavetable_oscillator_interp i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [PHASE_W-1:0]         osc_phase;
   logic [STEP_W-1:0]          osc_step;
   logic                       note_gate;
   logic [AMP_W-1:0]           gain;
   logic [SEL_W-1:0]           voice_table;
   logic signed [SAMPLE_W-1:0] wave_mem [TABLE_COUNT][TABLE_DEPTH];
   bit                         entry_written [TABLE_COUNT][TABLE_DEPTH];

   logic signed [SAMPLE_W-1:0] expected_samples [$];
   int                         error_count;
   int                         items_sent;
   bit                         idling_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void advance_oscillator(req_item_type it);
      logic [IDX_W-1:0]           idx;
      logic [IDX_W-1:0]           nxt;
      logic signed [SAMPLE_W-1:0] sample;
      longint                     s1, s2, frac, interp, amp_l, lvl_l, prod, mag;
      case (it.opcode)
         OP_TICK: begin
            if (it.env_off && (!note_gate || it.env_level <= SILENT_LEVEL)) begin
               expected_samples.push_back('0);
            end else begin
               idx = osc_phase[FRAC_W +: IDX_W];
               nxt = idx + 1'b1;
               frac = longint'(osc_phase[FRAC_W-1:0]);
               s1 = longint'(wave_mem[voice_table][idx]);
               s2 = longint'(wave_mem[voice_table][nxt]);
               interp = s1 + (((s2 - s1) * frac) >>> FRAC_W);
               amp_l = longint'(gain);
               lvl_l = longint'(it.env_level);
               prod = interp * amp_l * lvl_l;
               mag = (prod < 0) ? -prod : prod;
               mag = mag / FULL_SCALE;
               if (mag > longint'(SAMPLE_MAX)) mag = longint'(SAMPLE_MAX);
               sample = SAMPLE_W'((prod < 0) ? -mag : mag);
               expected_samples.push_back(sample);
               osc_phase = osc_phase + osc_step;
            end
         end
         OP_NOTE_ON: begin
            note_gate = 1'b1;
            osc_step = it.phase_step;
         end
         OP_NOTE_OFF: begin
            note_gate = 1'b0;
         end
         OP_RESET: begin
            osc_phase = '0;
            note_gate = 1'b0;
         end
         OP_TABLE_WRITE: begin
            if (it.table_select < TABLE_COUNT) begin
               wave_mem[it.table_select][it.table_addr] = it.table_value;
               entry_written[it.table_select][it.table_addr] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_item_type make_item(logic [OPCODE_W-1:0] op);
      req_item_type it;
      it.opcode = op;
      it.env_level = LEVEL_W'($urandom);
      it.env_off = 1'($urandom);
      it.phase_step = STEP_W'($urandom);
      it.table_select = SEL_W'($urandom);
      it.table_addr = TADDR_W'($urandom);
      it.table_value = SAMPLE_W'($urandom);
      return it;
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return UNITY_LEVEL;
         1: return LEVEL_W'($urandom_range(0, UNITY_LEVEL));
         2: return LEVEL_W'($urandom_range(SILENT_LEVEL - 5, SILENT_LEVEL + 5));
         3: return LEVEL_W'($urandom_range(UNITY_LEVEL + 1, LEVEL_MAX));
         default: return LEVEL_W'($urandom_range(30000, UNITY_LEVEL));
      endcase
   endfunction

   task automatic send_item(input req_item_type it);
      bit ready_seen;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.item <= it;
      do begin
         @(negedge clock);
         ready_seen = req_ch.ready;
         @(posedge clock);
      end while (!ready_seen);
      advance_oscillator(it);
      items_sent++;
   endtask

   task automatic write_entry(input logic [SEL_W-1:0] sel, input logic [TADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] value);
      req_item_type it;
      it = make_item(OP_TABLE_WRITE);
      it.table_select = sel;
      it.table_addr = addr;
      it.table_value = value;
      send_item(it);
   endtask

   // A tick reads the entry at the phase index and the one after it, so both
   // get a random value first if they were never written.
   task automatic send_tick(input logic [LEVEL_W-1:0] level, input logic off);
      req_item_type     it;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] nxt;
      idx = osc_phase[FRAC_W +: IDX_W];
      nxt = idx + 1'b1;
      if (!entry_written[voice_table][idx]) begin
         write_entry(voice_table, idx, SAMPLE_W'($urandom));
      end
      if (!entry_written[voice_table][nxt]) begin
         write_entry(voice_table, nxt, SAMPLE_W'($urandom));
      end
      it = make_item(OP_TICK);
      it.env_level = level;
      it.env_off = off;
      send_item(it);
   endtask

   task automatic start_note(input logic [STEP_W-1:0] step);
      req_item_type it;
      it = make_item(OP_NOTE_ON);
      it.phase_step = step;
      send_item(it);
   endtask

   task automatic wait_for_samples();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_for_samples();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_AMPLITUDE) begin
         gain = data[AMP_W-1:0];
      end else if (data[SEL_W-1:0] < TABLE_COUNT) begin
         voice_table = data[SEL_W-1:0];
      end
   endtask

   task automatic test_special_cases();
      send_item(make_item(OP_RESET));
      write_entry('0, '0, 16'sh8000);
      write_entry('0, TADDR_W'(1), 16'sh7FFF);
      write_entry('0, TADDR_W'(TABLE_DEPTH - 1), 16'sh7FFF);
      start_note(24'h000080);
      send_tick(UNITY_LEVEL, 1'b0);
      send_tick(LEVEL_MAX, 1'b0);
      send_tick(LEVEL_MAX, 1'b0);
      send_tick(SILENT_LEVEL, 1'b1);
      send_tick(SILENT_LEVEL + 1'b1, 1'b1);
      send_tick('0, 1'b0);
      send_item(make_item(OP_NOTE_OFF));
      send_tick(UNITY_LEVEL, 1'b1);
      send_tick(UNITY_LEVEL, 1'b0);
      send_item(make_item(OP_RESET));
      start_note(24'h07FF80);
      send_tick(UNITY_LEVEL, 1'b0);
      send_tick(UNITY_LEVEL, 1'b0);
      start_note(24'hFFFFFF);
      send_tick(UNITY_LEVEL, 1'b0);
      send_tick(UNITY_LEVEL, 1'b0);
      start_note('0);
      send_tick(UNITY_LEVEL, 1'b0);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
         send_item(make_item(OPCODE_W'(op)));
      end
      write_entry(SEL_W'(TABLE_COUNT), TADDR_W'($urandom), SAMPLE_W'($urandom));
      write_entry(SEL_W'(TABLE_COUNT + 1), TADDR_W'($urandom), SAMPLE_W'($urandom));
   endtask

   task automatic test_registers();
      start_note(24'h012345);
      write_register(CSR_AMPLITUDE, '0);
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_AMPLITUDE, 7'd1);
      send_tick(LEVEL_MAX, 1'b0);
      write_register(CSR_WAVE_SELECT, CSR_DATA_W'(TABLE_COUNT - 1));
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_AMPLITUDE, AMP_RESET);
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_WAVE_SELECT, CSR_DATA_W'(TABLE_COUNT));
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_WAVE_SELECT, 7'h7F);
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_WAVE_SELECT, 7'h7A);
      send_tick(UNITY_LEVEL, 1'b0);
      write_register(CSR_WAVE_SELECT, '0);
      send_tick(UNITY_LEVEL, 1'b0);
   endtask

   task automatic test_random_notes();
      int                  first;
      logic [OPCODE_W-1:0] op;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         if (items_sent - first > RANDOM_ITEMS * 85 / 100) idling_on = 1'b0;
         case ($urandom_range(0, 19))
            0: begin
               wait_for_samples();
            end
            1: begin
               case ($urandom_range(0, 2))
                  0: write_register(CSR_AMPLITUDE, '0);
                  1: write_register(CSR_AMPLITUDE, AMP_RESET);
                  default: write_register(CSR_AMPLITUDE, CSR_DATA_W'($urandom));
               endcase
               write_register(CSR_WAVE_SELECT, CSR_DATA_W'($urandom));
            end
            2, 3: begin
               repeat ($urandom_range(1, 6)) begin
                  write_entry(SEL_W'($urandom_range(0, TABLE_COUNT + 1)),
                              TADDR_W'($urandom), SAMPLE_W'($urandom));
               end
            end
            4, 5: begin
               repeat ($urandom_range(1, 4)) begin
                  op = OPCODE_W'($urandom_range(0, OP_UNUSED_HI));
                  if (op == OP_TICK) begin
                     send_tick(pick_level(), $urandom_range(0, 1) == 1);
                  end else begin
                     send_item(make_item(op));
                  end
               end
            end
            default: begin
               if ($urandom_range(0, 3) == 0) send_item(make_item(OP_RESET));
               case ($urandom_range(0, 3))
                  0: start_note(STEP_W'($urandom_range(0, 255)));
                  1: start_note(STEP_W'($urandom));
                  default: start_note(STEP_W'($urandom_range(24'hF00000, 24'hFFFFFF)));
               endcase
               repeat ($urandom_range(4, 30)) begin
                  send_tick(pick_level(), $urandom_range(0, 7) == 0);
               end
               if ($urandom_range(0, 1) == 0) begin
                  send_item(make_item(OP_NOTE_OFF));
                  repeat ($urandom_range(1, 4)) begin
                     send_tick(pick_level(), $urandom_range(0, 1) == 1);
                  end
               end
            end
         endcase
      end
   endtask

   initial begin : sample_check
      logic         got_valid;
      logic         got_ready;
      logic         got_reset;
      rsp_item_type got;
      logic signed [SAMPLE_W-1:0] want;
      int           stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         got_valid = rsp_ch.valid;
         got_ready = rsp_ch.ready;
         got_reset = reset;
         got = rsp_ch.item;
         @(posedge clock);
         if (!got_reset && got_valid && got_ready) begin
            if (expected_samples.size() == 0) begin
               error_count++;
               $display("%0t: unexpected sample_out, expected none, actual %0d",
                        $time, got.sample_out);
            end else begin
               want = expected_samples.pop_front();
               if (got.sample_out !== want) begin
                  error_count++;
                  $display("%0t: sample_out expected %0d, actual %0d",
                           $time, want, got.sample_out);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(negedge clock);
         if (reset || csr_we || (req_ch.valid && req_ch.ready)
             || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.item = '0;
      osc_phase = '0;
      osc_step = '0;
      note_gate = 1'b0;
      gain = AMP_RESET;
      voice_table = '0;
      error_count = 0;
      items_sent = 0;
      idling_on = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;
      test_special_cases();
      test_registers();
      test_random_notes();
      wait_for_samples();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/wto_pkg.sv
src/wto_if.sv
src/wto_wave_mem.sv
src/wto_mul_unit.sv
src/wavetable_oscillator_interp.sv
test/wavetable_oscillator_interp_test.sv
